>>> src/md5hbi_pkg.sv
// ----------------------------------------------------------------------------
// md5hbi_pkg : shared definitions for the MD5 hash block index
// Widths, MD5 constants, round tables and the pipeline payload types.
// ----------------------------------------------------------------------------
package md5hbi_pkg;

  // Default values of the top-level parameters.
  localparam int unsigned BLOCKS_PER_PLANE_DEF = 1024;
  localparam int unsigned KEY_COPIES_DEF       = 8;

  // Field widths.
  localparam int unsigned PAGE_W   = 64;
  localparam int unsigned HIDX_W   = 6;
  localparam int unsigned SHIFT_W  = 6;
  localparam int unsigned DIGEST_W = 64;
  localparam int unsigned VB_W     = 10;
  localparam int unsigned WORD_W   = 32;

  // Round chain and remainder chain geometry.
  localparam int unsigned ROUNDS    = 64;
  localparam int unsigned DIGIT_W   = 4;
  localparam int unsigned MOD_STEPS = DIGEST_W / DIGIT_W;

  localparam int unsigned GROUP_SIZE = 4;

  // Configuration port.
  localparam int unsigned APB_AW = 3;
  localparam int unsigned APB_DW = 32;

  typedef enum logic {
    REG_PAGE_SHIFT = 1'b0
  } md5hbi_reg_e;

  // MD5 initial chaining values and the padding word.
  localparam logic [WORD_W-1:0] IV_A         = 32'h67452301;
  localparam logic [WORD_W-1:0] IV_B         = 32'hefcdab89;
  localparam logic [WORD_W-1:0] IV_C         = 32'h98badcfe;
  localparam logic [WORD_W-1:0] IV_D         = 32'h10325476;
  localparam logic [WORD_W-1:0] MD5_PAD_WORD = 32'h00000080;

  localparam logic [WORD_W-1:0] SIN_TAB [ROUNDS] = '{
    32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
    32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
    32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
    32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
    32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
    32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
    32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
    32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
    32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
    32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
    32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
    32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
    32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
    32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
    32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
    32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
  };

  localparam logic [4:0] ROT_TAB [16] = '{
    5'd7, 5'd12, 5'd17, 5'd22, 5'd5, 5'd9, 5'd14, 5'd20,
    5'd4, 5'd11, 5'd16, 5'd23, 5'd6, 5'd10, 5'd15, 5'd21
  };

  // Message word used by a round.
  function automatic logic [3:0] msg_index(logic [5:0] rnd);
    logic [3:0] idx;
    case (rnd[5:4])
      2'd0:    idx = rnd[3:0];
      2'd1:    idx = 4'((rnd * 6'd5) + 6'd1);
      2'd2:    idx = 4'((rnd * 6'd3) + 6'd5);
      default: idx = 4'(rnd * 6'd7);
    endcase
    return idx;
  endfunction

  // Left-rotate amount of a round.
  function automatic logic [4:0] rot_amount(logic [5:0] rnd);
    return ROT_TAB[{rnd[5:4], rnd[1:0]}];
  endfunction

  // Payload carried along the round chain.
  typedef struct packed {
    logic [WORD_W-1:0] a;
    logic [WORD_W-1:0] b;
    logic [WORD_W-1:0] c;
    logic [WORD_W-1:0] d;
    logic [WORD_W-1:0] key;
    logic [HIDX_W-1:0] hidx;
  } md5hbi_round_t;

  // Payload carried along the remainder chain.
  typedef struct packed {
    logic [DIGEST_W-1:0] digest;
    logic [DIGEST_W-1:0] shifted;
  } md5hbi_mod_t;

endpackage

>>> src/md5hbi_if.sv
// ----------------------------------------------------------------------------
// md5hbi_if : request and response channels of the MD5 hash block index
// Valid/ready channels carrying the input and result fields.
// ----------------------------------------------------------------------------
interface md5hbi_req_if;
  logic                            valid;
  logic                            ready;
  logic [md5hbi_pkg::PAGE_W-1:0]   logical_page;
  logic [md5hbi_pkg::HIDX_W-1:0]   hash_index;

  modport source (output valid, output logical_page, output hash_index, input ready);
  modport sink   (input valid, input logical_page, input hash_index, output ready);
endinterface

interface md5hbi_rsp_if;
  logic                            valid;
  logic                            ready;
  logic [md5hbi_pkg::DIGEST_W-1:0] digest;
  logic [md5hbi_pkg::VB_W-1:0]     virtual_block;
  logic [md5hbi_pkg::VB_W-1:0]     group_base;

  modport source (output valid, output digest, output virtual_block, output group_base,
                  input ready);
  modport sink   (input valid, input digest, input virtual_block, input group_base,
                  output ready);
endinterface

>>> src/md5hbi_round_cell.sv
// ----------------------------------------------------------------------------
// md5hbi_round_cell : one MD5 round as a pipeline cell
// Applies one fixed round to the chaining words and registers the result.
// ----------------------------------------------------------------------------
module md5hbi_round_cell #(
  parameter int unsigned ROUND      = 0,
  parameter int unsigned KEY_COPIES = md5hbi_pkg::KEY_COPIES_DEF
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      adv_i,
  input  logic                      valid_i,
  input  md5hbi_pkg::md5hbi_round_t state_i,
  output logic                      valid_o,
  output md5hbi_pkg::md5hbi_round_t state_o
);

  localparam logic [5:0] RND   = 6'(ROUND);
  localparam int unsigned GIDX = int'(md5hbi_pkg::msg_index(RND));
  localparam int unsigned ROT  = int'(md5hbi_pkg::rot_amount(RND));
  localparam logic [md5hbi_pkg::WORD_W-1:0] KCONST = md5hbi_pkg::SIN_TAB[ROUND];

  logic [md5hbi_pkg::WORD_W-1:0] f;
  logic [md5hbi_pkg::WORD_W-1:0] w;
  logic [md5hbi_pkg::WORD_W-1:0] sum;
  logic [md5hbi_pkg::WORD_W-1:0] rot;
  md5hbi_pkg::md5hbi_round_t     state_d;
  md5hbi_pkg::md5hbi_round_t     state_q;
  logic                          valid_q;

  always_comb begin
    case (RND[5:4])
      2'd0:    f = (state_i.b & state_i.c) | (~state_i.b & state_i.d);
      2'd1:    f = (state_i.d & state_i.b) | (~state_i.d & state_i.c);
      2'd2:    f = state_i.b ^ state_i.c ^ state_i.d;
      default: f = state_i.c ^ (state_i.b | ~state_i.d);
    endcase

    // The message block holds the key in its first words, then the pad word.
    if (GIDX < KEY_COPIES) begin
      w = state_i.key;
    end else if (GIDX == KEY_COPIES) begin
      w = md5hbi_pkg::MD5_PAD_WORD;
    end else begin
      w = '0;
    end

    sum = state_i.a + f + KCONST + w;
    rot = (sum << ROT) | (sum >> (md5hbi_pkg::WORD_W - ROT));

    state_d      = state_i;
    state_d.a    = state_i.d;
    state_d.d    = state_i.c;
    state_d.c    = state_i.b;
    state_d.b    = state_i.b + rot;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (adv_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      state_q <= state_d;
    end
  end

  assign valid_o = valid_q;
  assign state_o = state_q;

endmodule

>>> src/md5hbi_mod_cell.sv
// ----------------------------------------------------------------------------
// md5hbi_mod_cell : one digit step of the modulo reduction
// Folds one digit of the shifted digest into a running remainder.
// ----------------------------------------------------------------------------
module md5hbi_mod_cell #(
  parameter int unsigned STEP             = 0,
  parameter int unsigned BLOCKS_PER_PLANE = md5hbi_pkg::BLOCKS_PER_PLANE_DEF,
  localparam int unsigned MOD_W           = $clog2(BLOCKS_PER_PLANE)
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    adv_i,
  input  logic                    valid_i,
  input  md5hbi_pkg::md5hbi_mod_t data_i,
  input  logic [MOD_W-1:0]        rem_i,
  output logic                    valid_o,
  output md5hbi_pkg::md5hbi_mod_t data_o,
  output logic [MOD_W-1:0]        rem_o
);

  localparam logic [MOD_W:0] MODULUS = (MOD_W + 1)'(BLOCKS_PER_PLANE - 1);
  localparam int unsigned    TOP_BIT = md5hbi_pkg::DIGEST_W - 1 - md5hbi_pkg::DIGIT_W * STEP;

  logic [md5hbi_pkg::DIGIT_W-1:0] digit;
  logic [MOD_W:0]                 acc;
  logic [MOD_W-1:0]               rem_d;
  logic [MOD_W-1:0]               rem_q;
  md5hbi_pkg::md5hbi_mod_t        data_q;
  logic                           valid_q;

  // Shift one bit in and subtract the modulus once; the value stays below
  // twice the modulus, so a single compare keeps the remainder in range.
  always_comb begin
    digit = data_i.shifted[TOP_BIT -: md5hbi_pkg::DIGIT_W];
    rem_d = rem_i;
    acc   = '0;
    for (int j = md5hbi_pkg::DIGIT_W - 1; j >= 0; j--) begin
      acc = {rem_d, digit[j]};
      if (acc >= MODULUS) begin
        acc = acc - MODULUS;
      end
      rem_d = acc[MOD_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (adv_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      data_q <= data_i;
      rem_q  <= rem_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;
  assign rem_o   = rem_q;

endmodule

>>> src/md5_hash_block_index_top.sv
// ----------------------------------------------------------------------------
// md5_hash_block_index_top : MD5 based logical page to virtual block index
// Hashes a page key with one MD5 compression and reduces the digest to a
// virtual block and its group base.
// ----------------------------------------------------------------------------
//
//   Channel   Direction  Handshake           Contents
//   req_i     in         valid/ready         logical_page, hash_index
//   rsp_o     out        valid/ready         digest, virtual_block, group_base
//   APB       in/out     psel/penable/pready page_shift register at offset 0
//
// The block accepts one request per cycle while the response side takes its
// results, and returns one response per request, in order, after the key
// stage, 64 round cells, the final chaining addition register, the digest
// shift register and 16 remainder cells of four bits each.
// The whole chain moves on a single advance signal, so a stall at the
// response side holds every stage in place and lowers req_i.ready.
// Reset clears only the valid bits and page_shift; no clearing pass is needed.

module md5_hash_block_index_top #(
  parameter int unsigned BLOCKS_PER_PLANE = md5hbi_pkg::BLOCKS_PER_PLANE_DEF,
  parameter int unsigned KEY_COPIES       = md5hbi_pkg::KEY_COPIES_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  md5hbi_req_if.sink                        req_i,
  md5hbi_rsp_if.source                      rsp_o,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [md5hbi_pkg::APB_AW-1:0]     paddr,
  input  logic [md5hbi_pkg::APB_DW-1:0]     pwdata,
  output logic [md5hbi_pkg::APB_DW-1:0]     prdata,
  output logic                              pready
);

  localparam int unsigned MOD_W = $clog2(BLOCKS_PER_PLANE);
  localparam int unsigned STEPS = md5hbi_pkg::MOD_STEPS;

  // --------------------------------------------------------------------------
  // Configuration register. The register index is the word address, so only
  // address bit two decides which register a request reaches.
  // --------------------------------------------------------------------------
  logic [md5hbi_pkg::SHIFT_W-1:0] page_shift_q;
  logic                           cfg_wr;
  md5hbi_pkg::md5hbi_reg_e        cfg_reg;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign cfg_reg = md5hbi_pkg::md5hbi_reg_e'(paddr[2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      page_shift_q <= '0;
    end else if (cfg_wr && (cfg_reg == md5hbi_pkg::REG_PAGE_SHIFT)) begin
      page_shift_q <= pwdata[md5hbi_pkg::SHIFT_W-1:0];
    end
  end

  always_comb begin
    unique case (cfg_reg)
      md5hbi_pkg::REG_PAGE_SHIFT: prdata = md5hbi_pkg::APB_DW'(page_shift_q);
      default:                    prdata = '0;
    endcase
  end

  // --------------------------------------------------------------------------
  // Pipeline advance. Every stage moves together whenever the response
  // register is empty or its contents are being taken this cycle.
  // --------------------------------------------------------------------------
  logic adv;
  logic out_valid;

  assign adv         = !out_valid || rsp_o.ready;
  assign req_i.ready = adv;

  // --------------------------------------------------------------------------
  // Key stage: the page is shifted and its low word becomes the key. The
  // chaining words start from the standard initial values.
  // --------------------------------------------------------------------------
  logic                         round_vld [md5hbi_pkg::ROUNDS+1];
  md5hbi_pkg::md5hbi_round_t    round_st  [md5hbi_pkg::ROUNDS+1];
  logic [md5hbi_pkg::PAGE_W-1:0] page_shifted;
  md5hbi_pkg::md5hbi_round_t    key_d;
  logic                         key_vld_q;
  md5hbi_pkg::md5hbi_round_t    key_q;

  always_comb begin
    page_shifted = req_i.logical_page >> page_shift_q;
    key_d.a      = md5hbi_pkg::IV_A;
    key_d.b      = md5hbi_pkg::IV_B;
    key_d.c      = md5hbi_pkg::IV_C;
    key_d.d      = md5hbi_pkg::IV_D;
    key_d.key    = page_shifted[md5hbi_pkg::WORD_W-1:0];
    key_d.hidx   = req_i.hash_index;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_vld_q <= 1'b0;
    end else if (adv) begin
      key_vld_q <= req_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      key_q <= key_d;
    end
  end

  assign round_vld[0] = key_vld_q;
  assign round_st[0]  = key_q;

  // --------------------------------------------------------------------------
  // Round chain: one cell per MD5 round.
  // --------------------------------------------------------------------------
  for (genvar r = 0; r < md5hbi_pkg::ROUNDS; r++) begin : g_round
    md5hbi_round_cell #(
      .ROUND      (r),
      .KEY_COPIES (KEY_COPIES)
    ) u_round (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .adv_i   (adv),
      .valid_i (round_vld[r]),
      .state_i (round_st[r]),
      .valid_o (round_vld[r+1]),
      .state_o (round_st[r+1])
    );
  end

  // --------------------------------------------------------------------------
  // Final chaining addition. Only the upper two words form the digest.
  // --------------------------------------------------------------------------
  logic                           fin_vld_q;
  logic [md5hbi_pkg::DIGEST_W-1:0] fin_digest_q;
  logic [md5hbi_pkg::HIDX_W-1:0]   fin_hidx_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fin_vld_q <= 1'b0;
    end else if (adv) begin
      fin_vld_q <= round_vld[md5hbi_pkg::ROUNDS];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      fin_digest_q <= {round_st[md5hbi_pkg::ROUNDS].d + md5hbi_pkg::IV_D,
                       round_st[md5hbi_pkg::ROUNDS].c + md5hbi_pkg::IV_C};
      fin_hidx_q   <= round_st[md5hbi_pkg::ROUNDS].hidx;
    end
  end

  // --------------------------------------------------------------------------
  // Digest shift, then the remainder chain working from the top digit down.
  // --------------------------------------------------------------------------
  logic                    mod_vld [STEPS+1];
  md5hbi_pkg::md5hbi_mod_t mod_st  [STEPS+1];
  logic [MOD_W-1:0]        mod_rem [STEPS+1];
  logic                    shf_vld_q;
  md5hbi_pkg::md5hbi_mod_t shf_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      shf_vld_q <= 1'b0;
    end else if (adv) begin
      shf_vld_q <= fin_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      shf_q.digest  <= fin_digest_q;
      shf_q.shifted <= fin_digest_q >> fin_hidx_q;
    end
  end

  assign mod_vld[0] = shf_vld_q;
  assign mod_st[0]  = shf_q;
  assign mod_rem[0] = '0;

  for (genvar s = 0; s < STEPS; s++) begin : g_mod
    md5hbi_mod_cell #(
      .STEP             (s),
      .BLOCKS_PER_PLANE (BLOCKS_PER_PLANE)
    ) u_mod (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .adv_i   (adv),
      .valid_i (mod_vld[s]),
      .data_i  (mod_st[s]),
      .rem_i   (mod_rem[s]),
      .valid_o (mod_vld[s+1]),
      .data_o  (mod_st[s+1]),
      .rem_o   (mod_rem[s+1])
    );
  end

  // --------------------------------------------------------------------------
  // Response. The last remainder cell is the output register; the fields
  // keep their low ten bits when the plane is wider than that.
  // --------------------------------------------------------------------------
  logic [31:0]                 rem_ext;
  logic [md5hbi_pkg::VB_W-1:0] vblock;

  assign out_valid = mod_vld[STEPS];
  assign rem_ext   = 32'(mod_rem[STEPS]);
  assign vblock    = rem_ext[md5hbi_pkg::VB_W-1:0];

  assign rsp_o.valid         = out_valid;
  assign rsp_o.digest        = mod_st[STEPS].digest;
  assign rsp_o.virtual_block = vblock;
  assign rsp_o.group_base    = vblock & ~md5hbi_pkg::VB_W'(md5hbi_pkg::GROUP_SIZE - 1);

endmodule
